// ----- src/mavha_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavha_pkg
// Shared types and constants of the moving average hysteresis alarm unit.
// ----------------------------------------------------------------------------
package mavha_pkg;

  localparam int WINDOW_MAX_DEF = 32;
  localparam int WINDOW_MIN_DEF = 1;

  localparam int TEMP_W = 16;
  localparam int THR_W  = 13;
  localparam int HYS_W  = 10;
  localparam int WIN_W  = 6;
  localparam int CFG_W  = 13;
  localparam int IDX_W  = 2;

  localparam logic signed [THR_W-1:0] THRESHOLD_RST  = 13'sd1050;
  localparam logic        [HYS_W-1:0] HYSTERESIS_RST = 10'd30;
  localparam int                      WINDOW_RST     = 8;

  typedef enum logic [IDX_W-1:0] {
    CFG_THRESHOLD  = 2'd0,
    CFG_HYSTERESIS = 2'd1,
    CFG_WINDOW     = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_NODATA = 2'd0,
    ST_NORMAL = 2'd1,
    ST_ACTIVE = 2'd2
  } alarm_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic                     sample_valid;
  } sample_t;

  typedef struct packed {
    alarm_t                   alarm_state;
    logic signed [TEMP_W-1:0] average;
  } result_t;

endpackage

// ----- src/mavha_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavha_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module mavha_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/mavha_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavha_alu
// Shared adder/subtractor for accumulation, division steps and negation.
// ----------------------------------------------------------------------------
module mavha_alu #(
  parameter int W = 22
) (
  input  mavha_pkg::alu_op_t op,
  input  logic [W-1:0]       a,
  input  logic [W-1:0]       b,
  output logic [W-1:0]       y
);

  always_comb begin
    case (op)
      mavha_pkg::ALU_SUB: y = a - b;
      default:            y = a + b;
    endcase
  end

endmodule

// ----- src/moving_average_hysteresis_alarm_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moving_average_hysteresis_alarm_unit
// Windowed temperature average with a hysteresis alarm, one shared adder.
// ----------------------------------------------------------------------------
// One word in, one word out. A missing sample goes from acceptance straight
// to the done state. A valid sample is written to the store, then every
// stored sample is read through the store's read port into the shared adder,
// then the sum is divided by the fill count with one restoring division step
// per quotient bit on the same adder, SUM_W = 16 + clog2(WINDOW_MAX+1) bits
// (22 by default). The input stalls while a word is in progress and
// while a configuration write is presented; a finished result waits in the
// output register. A configuration write to a known index empties the window
// and returns the alarm to no data.
// ----------------------------------------------------------------------------
module moving_average_hysteresis_alarm_unit #(
  parameter int WINDOW_MAX = mavha_pkg::WINDOW_MAX_DEF,
  parameter int WINDOW_MIN = mavha_pkg::WINDOW_MIN_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  mavha_pkg::sample_t         item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output mavha_pkg::result_t         result,
  input  logic                       cfg_write,
  input  logic [mavha_pkg::IDX_W-1:0] cfg_index,
  input  logic [mavha_pkg::CFG_W-1:0] cfg_data
);

  localparam int AW    = $clog2(WINDOW_MAX);
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = mavha_pkg::TEMP_W + CNT_W;
  localparam int DC_W  = $clog2(SUM_W);
  localparam int TW    = mavha_pkg::TEMP_W;
  localparam int CW    = mavha_pkg::TEMP_W + 1;
  localparam int WIN_RST_CL = (mavha_pkg::WINDOW_RST < WINDOW_MIN) ? WINDOW_MIN :
                              (mavha_pkg::WINDOW_RST > WINDOW_MAX) ? WINDOW_MAX :
                              mavha_pkg::WINDOW_RST;

  typedef enum logic [2:0] {
    S_IDLE, S_WRITE, S_SUM, S_ABS, S_DIV, S_SIGN, S_CMP, S_DONE
  } state_t;

  state_t state;

  logic signed [mavha_pkg::THR_W-1:0] threshold;
  logic        [mavha_pkg::HYS_W-1:0] hysteresis;
  logic        [CNT_W-1:0]            window;

  logic [CNT_W-1:0]   fill_count;
  logic [AW-1:0]      write_position;
  mavha_pkg::alarm_t  alarm_status;
  logic [TW-1:0]      last_average;

  logic [TW-1:0]      temp;
  logic [CNT_W-1:0]   idx;
  logic [DC_W-1:0]    dcnt;
  logic [SUM_W-1:0]   acc;
  logic [SUM_W-1:0]   quo;
  logic [CNT_W:0]     rem;
  logic               neg;

  logic [TW-1:0]      rdata;
  mavha_pkg::alu_op_t alu_op;
  logic [SUM_W-1:0]   alu_a, alu_b, alu_y;

  logic [CNT_W:0]     rsh;
  logic [CNT_W-1:0]   pos_inc;
  logic [CNT_W-1:0]   cnt_dec;
  logic [mavha_pkg::WIN_W-1:0] win_in;
  logic signed [CW-1:0] avg_x, thr_x, low_x;

  mavha_ram #(.WIDTH(TW), .DEPTH(WINDOW_MAX)) u_store (
    .clk   (clk),
    .we    (state == S_WRITE),
    .waddr (write_position),
    .wdata (temp),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  mavha_alu #(.W(SUM_W)) u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  assign rsh     = {rem[CNT_W-1:0], quo[SUM_W-1]};
  assign pos_inc = CNT_W'(write_position) + 1'b1;
  assign cnt_dec = (fill_count == '0) ? '0 : fill_count - 1'b1;
  assign win_in  = cfg_data[mavha_pkg::WIN_W-1:0];
  assign avg_x   = CW'($signed(last_average));
  assign thr_x   = CW'(threshold);
  assign low_x   = thr_x - $signed(CW'(hysteresis));

  always_comb begin
    alu_op = mavha_pkg::ALU_SUB;
    alu_a  = '0;
    alu_b  = acc;
    unique case (state)
      S_SUM: begin
        alu_op = mavha_pkg::ALU_ADD;
        alu_a  = acc;
        alu_b  = SUM_W'($signed(rdata));
      end
      S_DIV: begin
        alu_a = SUM_W'(rsh);
        alu_b = SUM_W'(fill_count);
      end
      S_SIGN: begin
        alu_b = quo;
      end
      default: ;
    endcase
  end

  assign item_stall = (state != S_IDLE) || cfg_write;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      result_valid   <= 1'b0;
      threshold      <= mavha_pkg::THRESHOLD_RST;
      hysteresis     <= mavha_pkg::HYSTERESIS_RST;
      window         <= CNT_W'(WIN_RST_CL);
      fill_count     <= '0;
      write_position <= '0;
      alarm_status   <= mavha_pkg::ST_NODATA;
      last_average   <= '0;
    end else begin
      if (result_valid && !result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cfg_write) begin
            case (cfg_index)
              mavha_pkg::CFG_THRESHOLD: begin
                threshold <= $signed(cfg_data[mavha_pkg::THR_W-1:0]);
              end
              mavha_pkg::CFG_HYSTERESIS: begin
                hysteresis <= cfg_data[mavha_pkg::HYS_W-1:0];
              end
              mavha_pkg::CFG_WINDOW: begin
                if (int'(win_in) < WINDOW_MIN) begin
                  window <= CNT_W'(WINDOW_MIN);
                end else if (int'(win_in) > WINDOW_MAX) begin
                  window <= CNT_W'(WINDOW_MAX);
                end else begin
                  window <= CNT_W'(win_in);
                end
              end
              default: ;
            endcase
            if (cfg_index == mavha_pkg::CFG_THRESHOLD ||
                cfg_index == mavha_pkg::CFG_HYSTERESIS ||
                cfg_index == mavha_pkg::CFG_WINDOW) begin
              fill_count     <= '0;
              write_position <= '0;
              alarm_status   <= mavha_pkg::ST_NODATA;
              last_average   <= '0;
            end
          end else if (item_valid) begin
            temp <= item.temperature;
            if (item.sample_valid) begin
              state <= S_WRITE;
            end else begin
              fill_count <= cnt_dec;
              if (cnt_dec == '0) begin
                alarm_status <= mavha_pkg::ST_NODATA;
                last_average <= '0;
              end
              state <= S_DONE;
            end
          end
        end
        S_WRITE: begin
          write_position <= (pos_inc >= window) ? '0 : pos_inc[AW-1:0];
          if (fill_count < window) begin
            fill_count <= fill_count + 1'b1;
          end
          idx   <= '0;
          acc   <= '0;
          state <= S_SUM;
        end
        S_SUM: begin
          if (idx != '0) begin
            acc <= alu_y;
          end
          if (idx == fill_count) begin
            state <= S_ABS;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_ABS: begin
          neg   <= acc[SUM_W-1];
          quo   <= acc[SUM_W-1] ? alu_y : acc;
          rem   <= '0;
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (!alu_y[SUM_W-1]) begin
            rem <= alu_y[CNT_W:0];
            quo <= {quo[SUM_W-2:0], 1'b1};
          end else begin
            rem <= rsh;
            quo <= {quo[SUM_W-2:0], 1'b0};
          end
          dcnt <= dcnt + 1'b1;
          if (dcnt == DC_W'(SUM_W - 1)) begin
            state <= S_SIGN;
          end
        end
        S_SIGN: begin
          last_average <= neg ? alu_y[TW-1:0] : quo[TW-1:0];
          state        <= S_CMP;
        end
        S_CMP: begin
          if (alarm_status == mavha_pkg::ST_ACTIVE) begin
            if (avg_x <= low_x) begin
              alarm_status <= mavha_pkg::ST_NORMAL;
            end
          end else if (avg_x >= thr_x) begin
            alarm_status <= mavha_pkg::ST_ACTIVE;
          end else begin
            alarm_status <= mavha_pkg::ST_NORMAL;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result.alarm_state <= alarm_status;
            result.average     <= last_average;
            result_valid       <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/mavha_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavha_checker
// Port level checks of the alarm unit, bound to the top level.
// ----------------------------------------------------------------------------
module mavha_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_stall,
  input logic               result_valid,
  input logic               result_stall,
  input mavha_pkg::result_t result
);

  // busy after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("input not stalled after accepting a word");

  a_state_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.alarm_state != 2'd3)
    else $error("illegal alarm state code");

  a_nodata_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.alarm_state == mavha_pkg::ST_NODATA |-> result.average == '0)
    else $error("nonzero average with no data");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result word changed");

endmodule

bind moving_average_hysteresis_alarm_unit mavha_checker u_mavha_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the moving average hysteresis alarm unit against a local predictor.
// A short table of directed words and settings runs first: reset state,
// window clamping, the ignored register index, missing samples draining the
// window, and the threshold and sample extremes. Random phases follow, each
// with random setting writes and words clustered around the threshold. Both
// sides idle at random. Results are checked against the predictor or typed rows.
// ----------------------------------------------------------------------------
module testbench;
  import mavha_pkg::*;

  localparam logic [IDX_W-1:0] CFG_UNKNOWN = 2'd3;
  localparam int SCRIPT_ROWS  = 33;
  localparam int RANDOM_WORDS = 1150;

  typedef enum logic {
    ROW_WORD    = 1'b0,
    ROW_SETTING = 1'b1
  } row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [IDX_W-1:0]         index;
    logic [CFG_W-1:0]         data;
    logic signed [TEMP_W-1:0] temp;
    logic                     valid;
    logic                     typed;
    alarm_t                   want_state;
    logic signed [TEMP_W-1:0] want_avg;
  } script_row_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             item_valid;
  logic             item_stall;
  sample_t          item;
  logic             result_valid;
  logic             result_stall;
  result_t          result;
  logic             cfg_write;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  int      model_threshold;
  int      model_hysteresis;
  int      model_window;
  logic signed [TEMP_W-1:0] model_store [WINDOW_MAX_DEF];
  int      model_fill;
  int      model_wpos;
  alarm_t  model_alarm;
  int      model_average;

  result_t pending_results [$];
  int      errors = 0;
  bit      calm = 1'b0;

  // kind, index, data, temperature, valid, typed, state, average
  script_row_t script [SCRIPT_ROWS] = '{
    '{ROW_WORD,    CFG_THRESHOLD,  13'h0000,      0, 1'b0, 1'b1, ST_NODATA,      0},
    '{ROW_WORD,    CFG_THRESHOLD,  13'h0000,   1050, 1'b1, 1'b1, ST_ACTIVE,   1050},
    '{ROW_WORD,    CFG_THRESHOLD,  13'h0000,   1040, 1'b1, 1'b0, ST_NODATA,      0},
    '{ROW_WORD,    CFG_THRESHOLD,  13'h0000,    900, 1'b1, 1'b0, ST_NODATA,      0},
    '{ROW_WORD,    CFG_THRESHOLD,  13'h0000,   1200, 1'b1, 1'b0, ST_NODATA,      0},
    '{ROW_WORD,    CFG_THRESHOLD,  13'h0000,      0, 1'b0, 1'b0, ST_NODATA,      0},
    '{ROW_WORD,    CFG_THRESHOLD,  13'h0000,      0, 1'b0, 1'b0, ST_NODATA,      0},
    '{ROW_WORD,    CFG_THRESHOLD,  13'h0000,      0, 1'b0, 1'b0, ST_NODATA,      0},
    '{ROW_WORD,    CFG_THRESHOLD,  13'h0000,      0, 1'b0, 1'b1, ST_NODATA,      0},
    '{ROW_WORD,    CFG_THRESHOLD,  13'h0000,      0, 1'b0, 1'b1, ST_NODATA,      0},
    '{ROW_SETTING, CFG_WINDOW,     13'h0000,      0, 1'b0, 1'b0, ST_NODATA,      0},
    '{ROW_WORD,    CFG_THRESHOLD,  13'h0000,  32767, 1'b1, 1'b1, ST_ACTIVE,  32767},
    '{ROW_WORD,    CFG_THRESHOLD,  13'h0000, -32768, 1'b1, 1'b1, ST_NORMAL, -32768},
    '{ROW_SETTING, CFG_WINDOW,     13'h1FC3,      0, 1'b0, 1'b0, ST_NODATA,      0},
    '{ROW_WORD,    CFG_THRESHOLD,  13'h0000,     10, 1'b1, 1'b0, ST_NODATA,      0},
    '{ROW_WORD,    CFG_THRESHOLD,  13'h0000,     20, 1'b1, 1'b0, ST_NODATA,      0},
    '{ROW_SETTING, CFG_UNKNOWN,    13'h1FFF,      0, 1'b0, 1'b0, ST_NODATA,      0},
    '{ROW_WORD,    CFG_THRESHOLD,  13'h0000,      0, 1'b0, 1'b1, ST_NORMAL,     15},
    '{ROW_WORD,    CFG_THRESHOLD,  13'h0000,     -1, 1'b1, 1'b0, ST_NODATA,      0},
    '{ROW_WORD,    CFG_THRESHOLD,  13'h0000,     -2, 1'b1, 1'b0, ST_NODATA,      0},
    '{ROW_SETTING, CFG_THRESHOLD,  13'h1000,      0, 1'b0, 1'b0, ST_NODATA,      0},
    '{ROW_SETTING, CFG_HYSTERESIS, 13'h03FF,      0, 1'b0, 1'b0, ST_NODATA,      0},
    '{ROW_SETTING, CFG_WINDOW,     13'h003F,      0, 1'b0, 1'b0, ST_NODATA,      0},
    '{ROW_WORD,    CFG_THRESHOLD,  13'h0000,  -4096, 1'b1, 1'b1, ST_ACTIVE,  -4096},
    '{ROW_WORD,    CFG_THRESHOLD,  13'h0000, -32768, 1'b1, 1'b0, ST_NODATA,      0},
    '{ROW_WORD,    CFG_THRESHOLD,  13'h0000,     -1, 1'b1, 1'b0, ST_NODATA,      0},
    '{ROW_SETTING, CFG_THRESHOLD,  13'h0FFF,      0, 1'b0, 1'b0, ST_NODATA,      0},
    '{ROW_SETTING, CFG_HYSTERESIS, 13'h1C00,      0, 1'b0, 1'b0, ST_NODATA,      0},
    '{ROW_SETTING, CFG_WINDOW,     13'h0020,      0, 1'b0, 1'b0, ST_NODATA,      0},
    '{ROW_WORD,    CFG_THRESHOLD,  13'h0000,   4095, 1'b1, 1'b1, ST_ACTIVE,   4095},
    '{ROW_WORD,    CFG_THRESHOLD,  13'h0000,   4094, 1'b1, 1'b0, ST_NODATA,      0},
    '{ROW_WORD,    CFG_THRESHOLD,  13'h0000,   4097, 1'b1, 1'b0, ST_NODATA,      0},
    '{ROW_WORD,    CFG_THRESHOLD,  13'h0000,   4095, 1'b1, 1'b0, ST_NODATA,      0}
  };

  moving_average_hysteresis_alarm_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_window();
    foreach (model_store[i]) model_store[i] = '0;
    model_fill    = 0;
    model_wpos    = 0;
    model_alarm   = ST_NODATA;
    model_average = 0;
  endfunction

  function automatic void apply_setting(input logic [IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] data);
    int v;
    case (idx)
      CFG_THRESHOLD:  model_threshold = int'($signed(data[THR_W-1:0]));
      CFG_HYSTERESIS: model_hysteresis = int'(data[HYS_W-1:0]);
      CFG_WINDOW: begin
        v = int'(data[WIN_W-1:0]);
        if (v < WINDOW_MIN_DEF) v = WINDOW_MIN_DEF;
        if (v > WINDOW_MAX_DEF) v = WINDOW_MAX_DEF;
        model_window = v;
      end
      default: return;
    endcase
    clear_window();
  endfunction

  function automatic result_t predict_average(input sample_t w);
    int      sum;
    int      i;
    result_t r;
    if (!w.sample_valid) begin
      if (model_fill > 0) model_fill--;
      if (model_fill == 0) begin
        model_alarm   = ST_NODATA;
        model_average = 0;
      end
    end else begin
      if (model_wpos >= WINDOW_MAX_DEF) model_wpos = 0;
      model_store[model_wpos] = w.temperature;
      model_wpos++;
      if (model_wpos >= model_window) model_wpos = 0;
      if (model_fill < model_window) model_fill++;
      sum = 0;
      for (i = 0; i < model_fill; i++) sum += model_store[i];
      model_average = sum / model_fill;
      if (model_alarm == ST_ACTIVE) begin
        if (model_average <= model_threshold - model_hysteresis) model_alarm = ST_NORMAL;
      end else if (model_average >= model_threshold) begin
        model_alarm = ST_ACTIVE;
      end else begin
        model_alarm = ST_NORMAL;
      end
    end
    r.alarm_state = model_alarm;
    r.average     = model_average[TEMP_W-1:0];
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input sample_t w, input bit typed, input result_t want);
    int      gap;
    result_t predicted;
    gap = calm ? 0 : $urandom_range(0, 9);
    cfg_write = 1'b0;
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid = 1'b1;
    item       = w;
    do @(posedge clk); while (item_stall !== 1'b0);
    predicted = predict_average(w);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic settle();
    item_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_setting(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    apply_setting(idx, data);
    @(negedge clk);
  endtask

  initial begin : limit
    #(5_000_000);
    $display("tb: failure");
    $finish;
  end

  initial begin : sink
    int      hold;
    result_t want;
    result_stall = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        result_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      result_stall = 1'b0;
      do @(posedge clk); while (result_valid !== 1'b1);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word, state %0d average %0d",
                 $time, result.alarm_state, result.average);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (result.alarm_state !== want.alarm_state) begin
          $display("%0t: alarm_state expected %0d got %0d",
                   $time, want.alarm_state, result.alarm_state);
          errors++;
        end
        if (result.average !== want.average) begin
          $display("%0t: average expected %0d got %0d", $time, want.average, result.average);
          errors++;
        end
      end
      @(negedge clk);
    end
  end

  initial begin : source
    int               k;
    int               len;
    int               burst;
    int               span;
    int               t;
    int               sent;
    sample_t          w;
    result_t          want;
    logic [CFG_W-1:0] d;

    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    model_threshold  = int'(THRESHOLD_RST);
    model_hysteresis = int'(HYSTERESIS_RST);
    model_window     = WINDOW_RST;
    clear_window();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (k = 0; k < SCRIPT_ROWS; k++) begin
      if (script[k].kind == ROW_SETTING) begin
        settle();
        write_setting(script[k].index, script[k].data);
      end else begin
        w.temperature    = script[k].temp;
        w.sample_valid   = script[k].valid;
        want.alarm_state = script[k].want_state;
        want.average     = script[k].want_avg;
        send_word(w, script[k].typed, want);
      end
    end

    want = '0;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      settle();
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 4))
          0:       d = 13'h1000;
          1:       d = 13'h0FFF;
          2:       d = CFG_W'($urandom_range(0, 8191));
          default: d = CFG_W'(int'($urandom_range(0, 4000)) - 1000);
        endcase
        write_setting(CFG_THRESHOLD, d);
      end
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 4))
          0:       d = 13'h0000;
          1:       d = 13'h03FF;
          2:       d = CFG_W'($urandom_range(0, 8191));
          default: d = CFG_W'($urandom_range(0, 100));
        endcase
        write_setting(CFG_HYSTERESIS, d);
      end
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 5))
          0:       d = 13'h0000;
          1:       d = 13'h0001;
          2:       d = 13'h0020;
          3:       d = CFG_W'($urandom_range(0, 8191));
          default: d = CFG_W'($urandom_range(1, 8));
        endcase
        write_setting(CFG_WINDOW, d);
      end
      if ($urandom_range(0, 7) == 0) write_setting(CFG_UNKNOWN, CFG_W'($urandom_range(0, 8191)));

      calm  = ($urandom_range(0, 3) == 0);
      len   = $urandom_range(20, 80);
      burst = 0;
      span  = model_hysteresis + 40;
      repeat (len) begin
        case ($urandom_range(0, 19))
          0, 1, 2: t = int'($urandom_range(0, 65535)) - 32768;
          3: t = 32767;
          4: t = -32768;
          default: t = model_threshold - span + int'($urandom_range(0, 2 * span));
        endcase
        w.temperature = TEMP_W'(t);
        if (burst == 0 && $urandom_range(0, 24) == 0) burst = $urandom_range(1, model_window + 1);
        if (burst > 0) begin
          w.sample_valid = 1'b0;
          burst--;
        end else begin
          w.sample_valid = ($urandom_range(0, 9) != 0);
        end
        send_word(w, 1'b0, want);
        sent++;
      end
    end

    settle();
    repeat (80) @(negedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/mavha_pkg.sv
src/mavha_ram.sv
src/mavha_alu.sv
src/moving_average_hysteresis_alarm_unit.sv
src/mavha_checker.sv
bench/testbench.sv
